/* hdl/ecc_pkg.sv */
`timescale 1ns / 1ps
package ecc_pkg;

	localparam logic [31:0] EPOCH_LOW  = 32'd946684800;
	localparam logic [31:0] EPOCH_HIGH = 32'd4102444799;
	localparam logic [16:0] SECS_DAY   = 17'd86400;
	localparam logic [16:0] SECS_HOUR  = 17'd3600;
	localparam logic [16:0] SECS_MIN   = 17'd60;
	localparam logic [16:0] DAYS_WEEK  = 17'd7;
	localparam logic [15:0] DAYS_TO_2000 = 16'd10957;
	localparam logic [6:0]  LAST_OFFSET  = 7'd99;

	// scaled reciprocals: quotient = (n * RCP) >> k, exact over the operand range
	localparam logic [25:0] RCP_DAY  = 26'd50903317;  // ceil(2^35 / 675), operand e >> 7
	localparam logic [16:0] RCP_WEEK = 17'd74899;     // ceil(2^19 / 7)
	localparam logic [13:0] RCP_HOUR = 14'd9321;      // ceil(2^21 / 225), operand sod >> 4
	localparam logic [10:0] RCP_MIN  = 11'd1093;      // ceil(2^14 / 15), operand sod >> 2

	// divider jobs of the epoch path
	localparam logic [1:0] DIV_DAY  = 2'd0;
	localparam logic [1:0] DIV_WEEK = 2'd1;
	localparam logic [1:0] DIV_HOUR = 2'd2;
	localparam logic [1:0] DIV_MIN  = 2'd3;

	localparam logic OP_TO_EPOCH = 1'b0;

	typedef struct packed {
		logic        opcode;
		logic [31:0] epoch_in;
		logic [7:0]  year_offset_in;
		logic [7:0]  month_in;
		logic [7:0]  day_in;
		logic [7:0]  hours_in;
		logic [7:0]  minutes_in;
		logic [7:0]  seconds_in;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] epoch_out;
		logic [6:0]  year_offset_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [2:0]  weekday_out;
		logic [4:0]  hours_out;
		logic [5:0]  minutes_out;
		logic [5:0]  seconds_out;
	} out_item_t;

	typedef struct packed {
		logic       load;
		logic       init;
		logic       yr_step;
		logic       mon_step;
		logic       mul;
		logic       sum;
		logic       div_start;
		logic       div_cap;
		logic [1:0] div_sel;
		logic       wr_out;
	} dp_cmd_t;

	typedef struct packed {
		logic op;
		logic ok;
		logic yr_done;
		logic mon_done;
		logic div_done;
	} dp_sts_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] n;
		unique case (m)
			4'd2:                       n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    n = 5'd30;
			default:                    n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

/* hdl/ecc_if.sv */
`timescale 1ns / 1ps
interface ecc_in_if;
	import ecc_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ecc_out_if;
	import ecc_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/ecc_div.sv */
`timescale 1ns / 1ps
module ecc_div
	import ecc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  sel,
	input  logic [31:0] dividend,
	output logic        done,
	output logic [15:0] quo,
	output logic [16:0] rem
);

	logic        v1_q;
	logic        v2_q;
	logic        done_q;
	logic [1:0]  sel_q;
	logic [31:0] num_q;
	logic [15:0] quo_q;
	logic [16:0] rem_q;
	logic [50:0] p_day;
	logic [32:0] p_week;
	logic [26:0] p_hour;
	logic [20:0] p_min;
	logic [15:0] est;
	logic [16:0] den;
	logic [32:0] back;

	// quotient estimates: multiply by a scaled reciprocal, keep the high bits
	assign p_day  = 51'(num_q[31:7]) * 51'(RCP_DAY);
	assign p_week = 33'(num_q[15:0]) * 33'(RCP_WEEK);
	assign p_hour = 27'(num_q[16:4]) * 27'(RCP_HOUR);
	assign p_min  = 21'(num_q[11:2]) * 21'(RCP_MIN);

	always_comb begin
		unique case (sel_q)
			DIV_DAY: begin
				est = p_day[50:35];           den = SECS_DAY;
			end
			DIV_WEEK: begin
				est = {2'd0, p_week[32:19]};  den = DAYS_WEEK;
			end
			DIV_HOUR: begin
				est = {10'd0, p_hour[26:21]}; den = SECS_HOUR;
			end
			default: begin
				est = {9'd0, p_min[20:14]};   den = SECS_MIN;
			end
		endcase
	end

	// multiply back to get the remainder
	assign back = 33'(quo_q) * 33'(den);

	// advance the three-stage job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v1_q   <= start;
			v2_q   <= v1_q;
			done_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			sel_q <= sel;
		end
		if (v1_q)
			quo_q <= est;
		if (v2_q)
			rem_q <= 17'(num_q - back[31:0]);
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

/* hdl/ecc_dp.sv */
`timescale 1ns / 1ps
module ecc_dp
	import ecc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	output out_item_t result
);

	in_item_t    it_q;
	logic        ok_q;
	logic [6:0]  cnt_q;
	logic [3:0]  mon_q;
	logic [15:0] days_q;
	logic [31:0] prod_q;
	logic [16:0] sod_q;
	logic [2:0]  wd_q;
	logic [4:0]  hr_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	out_item_t   res_q;
	out_item_t   res_d;

	logic        in_leap;
	logic        cnt_leap;
	logic        cal_ok;
	logic        ep_ok;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [31:0] div_num;
	logic        div_done;
	logic [15:0] div_quo;
	logic [16:0] div_rem;
	logic [15:0] dsum;

	// years 2000..2099: leap exactly when the offset is a multiple of four
	assign in_leap  = (it_q.year_offset_in[1:0] == 2'd0);
	assign cnt_leap = (cnt_q[1:0] == 2'd0);
	assign ylen     = cnt_leap ? 9'd366 : 9'd365;
	assign mlen     = month_len(cnt_leap, mon_q);

	// input range checks
	assign cal_ok = (it_q.year_offset_in <= 8'(LAST_OFFSET))
		&& (it_q.month_in >= 8'd1) && (it_q.month_in <= 8'd12)
		&& (it_q.day_in >= 8'd1)
		&& (it_q.day_in <= 8'(month_len(in_leap, it_q.month_in[3:0])))
		&& (it_q.hours_in <= 8'd23) && (it_q.minutes_in <= 8'd59)
		&& (it_q.seconds_in <= 8'd59);
	assign ep_ok = (it_q.epoch_in >= EPOCH_LOW) && (it_q.epoch_in <= EPOCH_HIGH);

	assign sts.op       = it_q.opcode;
	assign sts.ok       = (it_q.opcode == OP_TO_EPOCH) ? cal_ok : ep_ok;
	assign sts.yr_done  = (it_q.opcode == OP_TO_EPOCH) ? (cnt_q == it_q.year_offset_in[6:0])
		: ((cnt_q == LAST_OFFSET) || (days_q < 16'(ylen)));
	assign sts.mon_done = (it_q.opcode == OP_TO_EPOCH) ? (mon_q == it_q.month_in[3:0])
		: ((mon_q == 4'd12) || (days_q < 16'(mlen)));
	assign sts.div_done = div_done;

	// operand of each divider job
	always_comb begin
		unique case (cmd.div_sel)
			DIV_DAY:  div_num = it_q.epoch_in;
			DIV_WEEK: div_num = {16'd0, 16'(days_q + 16'd3)};
			DIV_HOUR: div_num = {15'd0, sod_q};
			default:  div_num = {15'd0, sod_q};
		endcase
	end

	ecc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sel      (cmd.div_sel),
		.dividend (div_num),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign dsum = days_q + 16'(it_q.day_in) - 16'd1;

	// result: status 1 and all other fields zero on a failed check
	always_comb begin
		res_d = '0;
		if (!ok_q)
			res_d.status = 1'b1;
		else if (it_q.opcode == OP_TO_EPOCH)
			res_d.epoch_out = prod_q;
		else begin
			res_d.year_offset_out = cnt_q;
			res_d.month_out       = mon_q;
			res_d.day_out         = days_q[4:0] + 5'd1;
			res_d.weekday_out     = wd_q;
			res_d.hours_out       = hr_q;
			res_d.minutes_out     = min_q;
			res_d.seconds_out     = sec_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			it_q <= in_item;
		if (cmd.init) begin
			ok_q   <= sts.ok;
			cnt_q  <= '0;
			mon_q  <= 4'd1;
			days_q <= DAYS_TO_2000;
		end
		if (cmd.yr_step) begin
			cnt_q  <= cnt_q + 7'd1;
			days_q <= (it_q.opcode == OP_TO_EPOCH) ? 16'(days_q + 16'(ylen))
				: 16'(days_q - 16'(ylen));
		end
		if (cmd.mon_step) begin
			mon_q  <= mon_q + 4'd1;
			days_q <= (it_q.opcode == OP_TO_EPOCH) ? 16'(days_q + 16'(mlen))
				: 16'(days_q - 16'(mlen));
		end
		if (cmd.mul)
			prod_q <= 32'({16'd0, dsum} * 32'(SECS_DAY));
		if (cmd.sum)
			prod_q <= prod_q + 32'(it_q.hours_in) * 32'(SECS_HOUR)
				+ 32'(it_q.minutes_in) * 32'(SECS_MIN) + 32'(it_q.seconds_in);
		if (cmd.div_cap) begin
			unique case (cmd.div_sel)
				DIV_DAY: begin
					days_q <= div_quo;
					sod_q  <= div_rem;
				end
				DIV_WEEK: begin
					wd_q   <= div_rem[2:0] + 3'd1;
					days_q <= days_q - DAYS_TO_2000;
				end
				DIV_HOUR: begin
					hr_q  <= div_quo[4:0];
					sod_q <= div_rem;
				end
				default: begin
					min_q <= div_quo[5:0];
					sec_q <= div_rem[5:0];
				end
			endcase
		end
		if (cmd.wr_out)
			res_q <= res_d;
	end

	assign result = res_q;

endmodule

/* hdl/ecc_ctrl.sv */
`timescale 1ns / 1ps
module ecc_ctrl
	import ecc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    idle
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_CYEAR = 4'd2;
	localparam logic [3:0] S_CMON  = 4'd3;
	localparam logic [3:0] S_CMUL  = 4'd4;
	localparam logic [3:0] S_CSUM  = 4'd5;
	localparam logic [3:0] S_DST   = 4'd6;
	localparam logic [3:0] S_DWT   = 4'd7;
	localparam logic [3:0] S_EYEAR = 4'd8;
	localparam logic [3:0] S_EMON  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	logic [3:0] state_q, state_d;
	logic [1:0] sel_q;
	logic       ovld_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovld_q;
	assign idle      = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				cmd.init = 1'b1;
				if (!sts.ok)
					state_d = S_FIN;
				else if (sts.op == OP_TO_EPOCH)
					state_d = S_CYEAR;
				else
					state_d = S_DST;
			end
			S_CYEAR: if (sts.yr_done) state_d = S_CMON; else cmd.yr_step = 1'b1;
			S_CMON:  if (sts.mon_done) state_d = S_CMUL; else cmd.mon_step = 1'b1;
			S_CMUL: begin
				cmd.mul = 1'b1;
				state_d = S_CSUM;
			end
			S_CSUM: begin
				cmd.sum = 1'b1;
				state_d = S_FIN;
			end
			S_DST: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWT;
			end
			S_DWT: if (sts.div_done) begin
				cmd.div_cap = 1'b1;
				state_d     = (sel_q == DIV_MIN) ? S_EYEAR : S_DST;
			end
			S_EYEAR: if (sts.yr_done) state_d = S_EMON; else cmd.yr_step = 1'b1;
			S_EMON:  if (sts.mon_done) state_d = S_FIN; else cmd.mon_step = 1'b1;
			S_FIN: if (!ovld_q || out_ready) begin
				cmd.wr_out = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance state, divider job and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= DIV_DAY;
			ovld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK)
				sel_q <= DIV_DAY;
			else if (cmd.div_cap)
				sel_q <= sel_q + 2'd1;
			if (cmd.wr_out)
				ovld_q <= 1'b1;
			else if (out_ready)
				ovld_q <= 1'b0;
		end
	end

endmodule

/* hdl/epoch_calendar_converter_top.sv */
`timescale 1ns / 1ps
// Epoch / calendar converter, Gregorian years 2000 to 2099.
// in_ch carries one request beat: opcode 0 turns the calendar fields into
// Unix seconds, opcode 1 turns epoch_in into year offset, month, day,
// weekday (Monday 1) and time of day. out_ch carries one result beat per
// request; on a failed range check status is 1 and all other fields are 0.
// Both channels move a beat when valid and ready are high at a clock edge.
// Calendar to epoch walks the year offset and the months, then multiplies
// the day count and adds the time of day. Epoch to calendar runs four
// divisions by constants through a reciprocal multiplier and then the year
// and month walks. A failed check goes straight to the result. The
// controller handles one request at a time; in_ch.ready is high only
// while it is idle, and the year walk dominates the time per item.
// A finished result sits in the output register; the next request is taken
// while it waits, but its result is held until out_ch.ready takes the old one.
// Reset (arst_n low) clears out_ch.valid and returns to idle.
module epoch_calendar_converter_top
	import ecc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ecc_in_if.sink    in_ch,
	ecc_out_if.source out_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    idle;

	ecc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle)
	);

	ecc_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_ch.data),
		.cmd     (cmd),
		.sts     (sts),
		.result  (out_ch.data)
	);

`ifndef SYNTHESIS
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.data.status |-> out_ch.data.epoch_out == 32'd0
			&& out_ch.data.month_out == 4'd0 && out_ch.data.weekday_out == 3'd0)
		else $error("invalid result carries nonzero fields");
	a_cal_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.status && out_ch.data.month_out != 4'd0
			|-> out_ch.data.day_out != 5'd0 && out_ch.data.weekday_out != 3'd0
			&& out_ch.data.epoch_out == 32'd0)
		else $error("calendar result malformed");
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !idle)
		else $error("controller idle after accepting a request");
`endif

endmodule

/* tb/sv/ecc_checker.sv */
`timescale 1ns / 1ps
module ecc_checker
	import ecc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ecc_in_if.sink      in_mon,
	ecc_out_if.sink     out_mon,
	output int          fail_count,
	output int          pending
);

	out_item_t expected_q[$];

	function automatic logic is_leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			2:          return is_leap(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:    return 31;
		endcase
	endfunction

	function automatic out_item_t convert(input in_item_t req);
		out_item_t r;
		int unsigned y, m, days, sod, e;
		r = '0;
		if (req.opcode == OP_TO_EPOCH) begin
			y = 2000 + req.year_offset_in;
			if (req.year_offset_in > 99 || req.month_in < 1 || req.month_in > 12 ||
				req.day_in < 1 || req.day_in > days_in_month(y, req.month_in) ||
				req.hours_in > 23 || req.minutes_in > 59 || req.seconds_in > 59) begin
				r.status = 1'b1;
				return r;
			end
			days = 0;
			for (int unsigned k = 1970; k < y; k++)
				days += is_leap(k) ? 366 : 365;
			for (int unsigned k = 1; k < req.month_in; k++)
				days += days_in_month(y, k);
			days += req.day_in - 1;
			r.epoch_out = days * 86400 + req.hours_in * 3600 + req.minutes_in * 60
				+ req.seconds_in;
		end else begin
			e = req.epoch_in;
			if (e < EPOCH_LOW || e > EPOCH_HIGH) begin
				r.status = 1'b1;
				return r;
			end
			days = e / 86400;
			sod = e % 86400;
			r.weekday_out = 3'(((days + 3) % 7) + 1);
			y = 1970;
			m = 1;
			while (y < 2099 && days >= (is_leap(y) ? 366 : 365)) begin
				days -= is_leap(y) ? 366 : 365;
				y++;
			end
			while (m < 12 && days >= days_in_month(y, m)) begin
				days -= days_in_month(y, m);
				m++;
			end
			r.year_offset_out = 7'(y - 2000);
			r.month_out = 4'(m);
			r.day_out = 5'(days + 1);
			r.hours_out = 5'(sod / 3600);
			r.minutes_out = 6'((sod % 3600) / 60);
			r.seconds_out = 6'(sod % 60);
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	// predict on each request beat, compare on each result beat
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				expected_q.push_back(convert(in_mon.data));
			if (out_mon.valid && out_mon.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, out_mon.data);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (want !== out_mon.data) begin
						$display("%0t: mismatch expected %p actual %p", $time, want,
							out_mon.data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/sv/epoch_calendar_converter_top_tb.sv */
`timescale 1ns / 1ps
module epoch_calendar_converter_top_tb;
	import ecc_pkg::*;

	localparam int RANDOM_BEATS = 1650;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	longint cycles = 0;
	logic hold_off = 1'b0;
	logic hold_go = 1'b0;

	ecc_in_if  in_ch();
	ecc_out_if out_ch();

	epoch_calendar_converter_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	ecc_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch.sink),
		.out_mon    (out_ch.sink),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #10 clk = ~clk;

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// stall the result side at random, with a long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off)
				out_ch.ready <= 1'b0;
			else if (cycles % 4000 < 1500)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// hold the result side off for a long stretch once asked to
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (600) @(posedge clk);
		hold_off <= 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(input in_item_t req);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.data  <= req;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic in_item_t rand_item();
		in_item_t r;
		int unsigned lo, hi;
		r = '0;
		r.opcode = 1'($urandom_range(0, 1));
		r.epoch_in = $urandom;
		r.year_offset_in = 8'($urandom);
		r.month_in = 8'($urandom);
		r.day_in = 8'($urandom);
		r.hours_in = 8'($urandom);
		r.minutes_in = 8'($urandom);
		r.seconds_in = 8'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			// well-formed content, mostly in range
			lo = EPOCH_LOW;
			hi = EPOCH_HIGH;
			r.epoch_in = $urandom_range(hi, lo);
			r.year_offset_in = 8'($urandom_range(0, 99));
			r.month_in = 8'($urandom_range(1, 12));
			r.day_in = 8'($urandom_range(1, 31));
			r.hours_in = 8'($urandom_range(0, 23));
			r.minutes_in = 8'($urandom_range(0, 59));
			r.seconds_in = 8'($urandom_range(0, 59));
		end
		return r;
	endfunction

	function automatic in_item_t cal(input int yo, input int mo, input int d,
		input int h, input int mi, input int s);
		in_item_t r;
		r = '0;
		r.opcode = OP_TO_EPOCH;
		r.epoch_in = $urandom;
		r.year_offset_in = 8'(yo);
		r.month_in = 8'(mo);
		r.day_in = 8'(d);
		r.hours_in = 8'(h);
		r.minutes_in = 8'(mi);
		r.seconds_in = 8'(s);
		return r;
	endfunction

	function automatic in_item_t epo(input logic [31:0] e);
		in_item_t r;
		r = in_item_t'({$urandom, $urandom});
		r.opcode = ~OP_TO_EPOCH;
		r.epoch_in = e;
		return r;
	endfunction

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: range edges, leap rules, every invalid field
		send(cal(0, 1, 1, 0, 0, 0));
		send(cal(99, 12, 31, 23, 59, 59));
		send(cal(100, 1, 1, 0, 0, 0));
		send(cal(255, 255, 255, 255, 255, 255));
		send(cal(0, 2, 29, 12, 0, 0));
		send(cal(1, 2, 29, 0, 0, 0));
		send(cal(4, 2, 29, 0, 0, 0));
		send(cal(5, 0, 1, 0, 0, 0));
		send(cal(5, 13, 1, 0, 0, 0));
		send(cal(5, 4, 31, 0, 0, 0));
		send(cal(5, 4, 0, 0, 0, 0));
		send(cal(5, 4, 30, 24, 0, 0));
		send(cal(5, 4, 30, 0, 60, 0));
		send(cal(5, 4, 30, 0, 0, 60));
		send(epo(EPOCH_LOW));
		send(epo(EPOCH_LOW - 1));
		send(epo(EPOCH_HIGH));
		send(epo(EPOCH_HIGH + 1));
		send(epo(32'hFFFF_FFFF));
		send(epo(32'd0));
		send(epo(32'd951782400));
		send(epo(32'd4107542399 - 32'd5184000));

		// long result hold-off while requests keep coming
		hold_go <= 1'b1;
		for (int i = 0; i < 6; i++) send(rand_item());

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			send(rand_item());
			if (i == RANDOM_BEATS / 2) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
